### sv/cws_pkg.sv
// ----------------------------------------------------------------------------
// cws_pkg
// Shared types, codes and helpers for the CIGAR window splicer.
// ----------------------------------------------------------------------------
package cws_pkg;

  localparam int unsigned LenW   = 28;
  localparam int unsigned CodeW  = 4;
  localparam int unsigned CntW   = 32;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned CfgIdxW = 2;

  // BAM operation codes
  localparam logic [CodeW-1:0] OP_M  = 4'd0;
  localparam logic [CodeW-1:0] OP_I  = 4'd1;
  localparam logic [CodeW-1:0] OP_D  = 4'd2;
  localparam logic [CodeW-1:0] OP_N  = 4'd3;
  localparam logic [CodeW-1:0] OP_S  = 4'd4;
  localparam logic [CodeW-1:0] OP_EQ = 4'd7;
  localparam logic [CodeW-1:0] OP_X  = 4'd8;

  // Counting modes
  localparam logic [ModeW-1:0] MODE_ALL  = 2'd0;
  localparam logic [ModeW-1:0] MODE_REF  = 2'd1;
  localparam logic [ModeW-1:0] MODE_READ = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_OFFSET = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SIZE   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_MODE   = 2'd2;

  typedef enum logic [2:0] {
    PH_SKIP   = 3'b001,
    PH_INSIDE = 3'b010,
    PH_DONE   = 3'b100
  } phase_e;

  typedef struct packed {
    logic [LenW-1:0]  length;
    logic [CodeW-1:0] code;
    logic             last;
  } item_t;

  typedef struct packed {
    logic             emit_valid;
    logic [LenW-1:0]  length;
    logic [CodeW-1:0] code;
    logic             last;
  } result_t;

  function automatic logic op_counts(input logic [ModeW-1:0] mode,
                                     input logic [CodeW-1:0] code);
    logic hit;
    hit = 1'b1;
    case (mode)
      MODE_REF: begin
        case (code) inside
          OP_M, OP_D, OP_N, OP_EQ, OP_X: hit = 1'b1;
          default:                       hit = 1'b0;
        endcase
      end
      MODE_READ: begin
        case (code) inside
          OP_M, OP_I, OP_S, OP_EQ, OP_X: hit = 1'b1;
          default:                       hit = 1'b0;
        endcase
      end
      default: hit = 1'b1;
    endcase
    return hit;
  endfunction

endpackage

### sv/cigar_window_splicer_core.sv
// ----------------------------------------------------------------------------
// cigar_window_splicer_core
// Streaming CIGAR window splice: one op in, one result out, per cycle while the receiver does not stall.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one CIGAR op per item:
//   op_length_i, op_code_i (BAM encoding) and op_last_i on the final op of a
//   string. Output channel (out_valid_o / out_ready_i) carries exactly one
//   result item per input item: emit_valid_o says whether an op of the
//   spliced CIGAR is given in out_length_o / out_code_o; out_end_o copies the
//   last marker.
//   Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i
//   (0 window offset, 1 window size, 2 count mode). Each such write reloads
//   the counters and restarts the window. Write only while the block is idle.
//   An accepted item waits in the input register, passes the single trim stage
//   and is registered in the result register. Throughput: one item per cycle
//   while the receiver does not stall, set by that trim stage.
//   Reset clears the configuration registers and counters to zero, empties
//   both pipeline registers and returns the phase to skipping. When the
//   receiver stalls, the result register holds and the input register can
//   still take one more item; after that in_ready_o drops.
// ----------------------------------------------------------------------------
module cigar_window_splicer_core
  import cws_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CntW-1:0]    cfg_data_i,
  // input channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [LenW-1:0]    op_length_i,
  input  logic [CodeW-1:0]   op_code_i,
  input  logic               op_last_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               emit_valid_o,
  output logic [LenW-1:0]    out_length_o,
  output logic [CodeW-1:0]   out_code_o,
  output logic               out_end_o
);

  // Configuration registers
  logic [CntW-1:0]  win_offset_q, win_offset_d;
  logic [CntW-1:0]  win_size_q, win_size_d;
  logic [ModeW-1:0] mode_q, mode_d;
  logic             reload;

  // Pipeline registers
  logic    in_valid_q;
  item_t   item_q;
  logic    out_valid_q;
  result_t result_q;
  result_t result;
  logic    advance;
  logic    fire;

  // Decode the write; the splice stage reloads from the new values.
  always_comb begin
    win_offset_d = win_offset_q;
    win_size_d   = win_size_q;
    mode_d       = mode_q;
    reload       = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_OFFSET: begin
          win_offset_d = cfg_data_i;
          reload       = 1'b1;
        end
        REG_SIZE: begin
          win_size_d = cfg_data_i;
          reload     = 1'b1;
        end
        REG_MODE: begin
          mode_d = cfg_data_i[ModeW-1:0];
          reload = 1'b1;
        end
        default: begin
          reload = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_offset_q <= '0;
      win_size_q   <= '0;
      mode_q       <= MODE_ALL;
    end else begin
      win_offset_q <= win_offset_d;
      win_size_q   <= win_size_d;
      mode_q       <= mode_d;
    end
  end

  // Advance the result register when it is empty or being drained.
  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  // Input register: take a new item whenever it is empty or the held one moves on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q.length <= op_length_i;
      item_q.code   <= op_code_i;
      item_q.last   <= op_last_i;
    end
  end

  cws_splice u_splice (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .item_i       (item_q),
    .reload_i     (reload),
    .win_offset_i (win_offset_d),
    .win_size_i   (win_size_d),
    .mode_i       (mode_q),
    .result_o     (result)
  );

  // Result register: hold while the receiver stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      result_q <= result;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign emit_valid_o = result_q.emit_valid;
  assign out_length_o = result_q.length;
  assign out_code_o   = result_q.code;
  assign out_end_o    = result_q.last;

  a_stall_keeps_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> in_valid_q && $stable(item_q))
    else $error("held item lost during stall");

  a_idle_emit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !emit_valid_o) |-> (out_length_o == '0) && (out_code_o == '0))
    else $error("non-emitted result carries payload");

  a_fire_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("processed item did not reach result register");

endmodule

### sv/cws_splice.sv
// ----------------------------------------------------------------------------
// cws_splice
// Window state (phase, offset and size counters) and the per-item trim logic.
// ----------------------------------------------------------------------------
module cws_splice
  import cws_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  item_t           item_i,
  input  logic            reload_i,
  input  logic [CntW-1:0] win_offset_i,
  input  logic [CntW-1:0] win_size_i,
  input  logic [ModeW-1:0] mode_i,
  output result_t         result_o
);

  phase_e          phase_q, phase_d, phase_n;
  logic [CntW-1:0] offset_left_q, offset_left_d, offset_left_n;
  logic [CntW-1:0] size_left_q, size_left_d, size_left_n;

  logic            counted;
  logic [CntW-1:0] len_ext;
  logic [LenW-1:0] rem;
  logic [CntW-1:0] size_sub;
  logic            valid;
  logic [LenW-1:0] olen;

  assign counted  = op_counts(mode_i, item_i.code);
  assign len_ext  = {{(CntW-LenW){1'b0}}, item_i.length};
  assign rem      = item_i.length - offset_left_q[LenW-1:0];
  assign size_sub = size_left_q - len_ext;

  always_comb begin
    phase_n       = phase_q;
    offset_left_n = offset_left_q;
    size_left_n   = size_left_q;
    valid         = 1'b0;
    olen          = '0;
    unique case (phase_q)
      PH_SKIP: begin
        if (!counted || offset_left_q >= len_ext) begin
          if (counted) begin
            offset_left_n = offset_left_q - len_ext;
          end
        end else begin
          valid = 1'b1;
          if ({{(CntW-LenW){1'b0}}, rem} >= size_left_q) begin
            olen    = size_left_q[LenW-1:0];
            phase_n = PH_DONE;
          end else begin
            olen        = rem;
            size_left_n = size_left_q - {{(CntW-LenW){1'b0}}, rem};
            phase_n     = PH_INSIDE;
          end
        end
      end
      PH_INSIDE: begin
        valid = 1'b1;
        if (!counted || size_left_q >= len_ext) begin
          olen = item_i.length;
          if (counted) begin
            size_left_n = size_sub;
          end
          if (size_left_n == '0) begin
            phase_n = PH_DONE;
          end
        end else begin
          olen        = size_left_q[LenW-1:0];
          size_left_n = '0;
          phase_n     = PH_DONE;
        end
      end
      PH_DONE: begin
        valid = 1'b0;
      end
      default: begin
        phase_n = PH_SKIP;
      end
    endcase
  end

  // Reload on a config write or after the last op of a string.
  always_comb begin
    phase_d       = phase_q;
    offset_left_d = offset_left_q;
    size_left_d   = size_left_q;
    if (reload_i || (fire_i && item_i.last)) begin
      phase_d       = PH_SKIP;
      offset_left_d = win_offset_i;
      size_left_d   = win_size_i;
    end else if (fire_i) begin
      phase_d       = phase_n;
      offset_left_d = offset_left_n;
      size_left_d   = size_left_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_SKIP;
      offset_left_q <= '0;
      size_left_q   <= '0;
    end else begin
      phase_q       <= phase_d;
      offset_left_q <= offset_left_d;
      size_left_q   <= size_left_d;
    end
  end

  assign result_o.emit_valid = valid;
  assign result_o.length     = valid ? olen : '0;
  assign result_o.code       = valid ? item_i.code : '0;
  assign result_o.last       = item_i.last;

  a_last_returns_to_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && item_i.last) |=> (phase_q == PH_SKIP))
    else $error("phase not back to skip after last op");

  a_done_emits_nothing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DONE) |-> !result_o.emit_valid)
    else $error("emit after window complete");

  a_reload_counters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reload_i |=> (offset_left_q == $past(win_offset_i)) &&
                 (size_left_q == $past(win_size_i)))
    else $error("counters not reloaded on config write");

endmodule
